### hw/rtl/smtd_pkg.sv
// Package with shared constants and types of the sliding median threshold detector.
package smtd_pkg;
  localparam int SAMPLE_W = 8;
  localparam int DM_W = 9;
  localparam int CNT_W = 32;
  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd5;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [DM_W-1:0] dmed_t;
  typedef logic [CNT_W-1:0] count_t;
  typedef logic [CFG_W-1:0] cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_DONE = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;
endpackage

### hw/rtl/smtd_if.sv
// Handshake interfaces for the sample input channel and the result channel.
interface smtd_in_if;
  import smtd_pkg::*;
  logic valid;
  logic ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface smtd_out_if;
  import smtd_pkg::*;
  logic valid;
  logic ready;
  logic window_ready;
  logic alert;
  dmed_t doubled_median;
  count_t alert_count;
  modport source (output valid, output window_ready, output alert,
                  output doubled_median, output alert_count, input ready);
  modport sink (input valid, input window_ready, input alert,
                input doubled_median, input alert_count, output ready);
endinterface

### hw/rtl/smtd_cell.sv
// One histogram bin cell of the rotating bin chain.
module smtd_cell #(
  parameter int CW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic          shift,
  input  logic [CW-1:0] d_in,
  output logic [CW-1:0] q
);
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (clr) begin
      cnt_nxt = '0;
    end else if (shift) begin
      cnt_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign q = cnt_r;
endmodule

### hw/rtl/sliding_median_threshold_detector_top.sv
// Top level of the sliding median threshold detector.
//   channel | direction | fields
//   in_ch   | sink      | sample
//   out_ch  | source    | window_ready, alert, doubled_median, alert_count
//   cfg     | write     | window_length (cfg_we, cfg_data)
// Each word passes an accept step with its ring read, a setup step and one pass
// of the bin chain rotating once through all VALUE_BINS cells, then a result step.
// The rotation finds both middle values and applies the bin updates in the same pass.
// Reset and a window length write clear all bins at once; no clearing pass is needed.
// A result waiting on out_ch does not block the next input word; a second result
// waits in the finishing cycle until the first one is taken.
module sliding_median_threshold_detector_top #(
  parameter int WINDOW_MAX = 1024,
  parameter int VALUE_BINS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  smtd_pkg::cfg_t        cfg_data,
  smtd_in_if.sink               in_ch,
  smtd_out_if.source            out_ch
);
  import smtd_pkg::*;

  localparam int LW = $clog2(WINDOW_MAX + 1);
  localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int BW = (VALUE_BINS > 1) ? $clog2(VALUE_BINS) : 1;

  state_t state_r, state_nxt;
  cfg_t len_cfg_r;
  logic [PW-1:0] ptr_r;
  logic [LW-1:0] fill_r;
  count_t total_r;
  sample_t s_r;
  sample_t old_r;
  logic [BW-1:0] idx_r;
  logic [LW:0] cum_r;
  logic lo_found_r, hi_found_r;
  logic [BW-1:0] lo_r, hi_r;
  logic full_r;

  logic ov_r;
  logic o_ready_r, o_alert_r;
  dmed_t o_dm_r;

  sample_t ring [WINDOW_MAX];

  logic [LW-1:0] len;
  logic [LW-1:0] rank_lo, rank_hi;
  logic [LW-1:0] head, head_mod;
  logic [LW-1:0] chain [VALUE_BINS];
  logic [LW:0] cum_n;
  logic [PW-1:0] ptr_use;
  logic scan_en, clr_hist;
  sample_t s_sat;
  dmed_t dm;

  always_comb begin
    if (len_cfg_r == '0) begin
      len = LW'(1);
    end else if (32'(len_cfg_r) > WINDOW_MAX) begin
      len = LW'(WINDOW_MAX);
    end else begin
      len = LW'(len_cfg_r);
    end
  end

  assign rank_lo = LW'((32'(len) + 1) / 2);
  assign rank_hi = LW'(32'(len) / 2 + 1);
  assign ptr_use = (32'(ptr_r) >= 32'(len)) ? '0 : ptr_r;
  assign s_sat = (32'(in_ch.sample) > VALUE_BINS - 1) ?
                 SAMPLE_W'(VALUE_BINS - 1) : in_ch.sample;

  assign scan_en = (state_r == ST_SCAN);
  assign clr_hist = cfg_we;
  assign head = chain[0];
  assign cum_n = cum_r + (LW + 1)'(head);

  always_comb begin
    head_mod = head;
    if (32'(idx_r) == 32'(s_r)) begin
      head_mod = head_mod + LW'(1);
    end
    if (full_r && (32'(idx_r) == 32'(old_r)) && (head != '0)) begin
      head_mod = head_mod - LW'(1);
    end
  end

  for (genvar g = 0; g < VALUE_BINS; g++) begin : g_bin
    logic [LW-1:0] d_in;
    if (g == VALUE_BINS - 1) begin : g_tail
      assign d_in = head_mod;
    end else begin : g_mid
      assign d_in = chain[g+1];
    end
    smtd_cell #(.CW(LW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .clr   (clr_hist),
      .shift (scan_en),
      .d_in  (d_in),
      .q     (chain[g])
    );
  end

  assign dm = DM_W'(32'(lo_r) + 32'(hi_r));
  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_SCAN;
      ST_SCAN: if (32'(idx_r) == VALUE_BINS - 1) state_nxt = ST_DONE;
      ST_DONE: if (!ov_r || out_ch.ready) state_nxt = ST_IDLE;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      ring[ptr_use] <= s_sat;
    end
    if (state_r == ST_IDLE) begin
      old_r <= ring[ptr_use];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      len_cfg_r  <= CFG_RESET;
      ptr_r      <= '0;
      fill_r     <= '0;
      total_r    <= '0;
      ov_r       <= 1'b0;
      full_r     <= 1'b0;
      idx_r      <= '0;
      cum_r      <= '0;
      lo_found_r <= 1'b0;
      hi_found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && (!ov_r || out_ch.ready)) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      if (cfg_we) begin
        len_cfg_r <= cfg_data;
        ptr_r     <= '0;
        fill_r    <= '0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            s_r    <= s_sat;
            full_r <= (32'(fill_r) >= 32'(len));
            if (32'(ptr_use) + 1 >= 32'(len)) begin
              ptr_r <= '0;
            end else begin
              ptr_r <= ptr_use + PW'(1);
            end
          end
        end
        ST_RD: begin
          idx_r      <= '0;
          cum_r      <= '0;
          lo_found_r <= 1'b0;
          hi_found_r <= 1'b0;
          lo_r       <= BW'(VALUE_BINS - 1);
          hi_r       <= BW'(VALUE_BINS - 1);
        end
        ST_SCAN: begin
          idx_r <= idx_r + BW'(1);
          cum_r <= cum_n;
          if (!lo_found_r && cum_n >= (LW + 1)'(rank_lo)) begin
            lo_found_r <= 1'b1;
            lo_r       <= idx_r;
          end
          if (!hi_found_r && cum_n >= (LW + 1)'(rank_hi)) begin
            hi_found_r <= 1'b1;
            hi_r       <= idx_r;
          end
        end
        ST_DONE: begin
          if (!ov_r || out_ch.ready) begin
            o_ready_r <= full_r;
            if (full_r) begin
              o_dm_r    <= dm;
              o_alert_r <= (DM_W'(s_r) >= dm);
              if ((DM_W'(s_r) >= dm) && (total_r != '1)) begin
                total_r <= total_r + CNT_W'(1);
              end
            end else begin
              o_dm_r    <= '0;
              o_alert_r <= 1'b0;
              fill_r    <= fill_r + LW'(1);
            end
          end
        end
        ST_OUT: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.window_ready   = o_ready_r;
  assign out_ch.alert          = o_alert_r;
  assign out_ch.doubled_median = o_dm_r;
  assign out_ch.alert_count    = total_r;

  a_alert_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.alert |-> out_ch.window_ready)
    else $error("alert without full window");
  a_dm_zero_unready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.window_ready |-> out_ch.doubled_median == '0)
    else $error("median reported before window full");
  a_count_grows_on_alert: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) && o_alert_r && $past(total_r) != '1 |-> total_r == $past(total_r) + 1)
    else $error("alert count did not advance");
  a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> !in_ch.ready)
    else $error("input taken during scan");
endmodule

### bench/sliding_median_threshold_detector_top_test.sv
// Testbench of the sliding median threshold detector with random and directed samples.
module sliding_median_threshold_detector_top_test;
  import smtd_pkg::*;

  localparam int WIN_MAX = 1024;
  localparam int BINS = 256;
  localparam int WORD_CYCLES = BINS + 3;
  localparam int STALL_LIMIT = 40 * WORD_CYCLES + 2000;

  typedef struct packed {
    logic window_ready;
    logic alert;
    dmed_t doubled_median;
    count_t alert_count;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_t cfg_data;

  smtd_in_if in_ch ();
  smtd_out_if out_ch ();

  sliding_median_threshold_detector_top i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  int unsigned hist[BINS];
  sample_t ring[WIN_MAX];
  int unsigned ring_ptr;
  int unsigned fill_cnt;
  int unsigned win_len;
  count_t alert_tally;

  sample_t pending_samples[$];
  verdict_t expected_verdicts[$];

  int send_idle_pct;
  int recv_stall_pct;
  bit failed = 1'b0;
  int unsigned quiet_cycles = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int unsigned value_at_rank(int unsigned rank);
    int unsigned cum;
    cum = 0;
    for (int i = 0; i < BINS; i++) begin
      cum += hist[i];
      if (cum >= rank) return i;
    end
    return BINS - 1;
  endfunction

  function automatic void clear_window();
    foreach (hist[i]) hist[i] = 0;
    ring_ptr = 0;
    fill_cnt = 0;
  endfunction

  function automatic verdict_t judge_sample(sample_t s);
    verdict_t v;
    int unsigned len;
    int unsigned ptr;
    int unsigned dm;
    sample_t old;
    v = '0;
    len = (win_len == 0) ? 1 : (win_len > WIN_MAX ? WIN_MAX : win_len);
    ptr = (ring_ptr >= len) ? 0 : ring_ptr;
    if (fill_cnt >= len) begin
      dm = value_at_rank((len + 1) / 2) + value_at_rank(len / 2 + 1);
      v.window_ready = 1'b1;
      v.doubled_median = dm[DM_W-1:0];
      if (s >= dm) begin
        v.alert = 1'b1;
        if (alert_tally != '1) alert_tally++;
      end
      old = ring[ptr];
      if (hist[old] != 0) hist[old]--;
    end else begin
      fill_cnt++;
    end
    ring[ptr] = s;
    hist[s]++;
    ptr++;
    ring_ptr = (ptr >= len) ? 0 : ptr;
    v.alert_count = alert_tally;
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.sample <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.sample <= pending_samples.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_verdicts.push_back(judge_sample(in_ch.sample));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result word with no expectation");
          failed = 1'b1;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_ch.window_ready !== want.window_ready) begin
            $error("window_ready: expected %0d, got %0d", want.window_ready,
                   out_ch.window_ready);
            failed = 1'b1;
          end
          if (out_ch.alert !== want.alert) begin
            $error("alert: expected %0d, got %0d", want.alert, out_ch.alert);
            failed = 1'b1;
          end
          if (out_ch.doubled_median !== want.doubled_median) begin
            $error("doubled_median: expected %0d, got %0d", want.doubled_median,
                   out_ch.doubled_median);
            failed = 1'b1;
          end
          if (out_ch.alert_count !== want.alert_count) begin
            $error("alert_count: expected %0d, got %0d", want.alert_count,
                   out_ch.alert_count);
            failed = 1'b1;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic drain();
    wait (pending_samples.size() == 0);
    @(posedge clk);
    while (in_ch.valid || expected_verdicts.size() > 0) @(posedge clk);
    repeat (WORD_CYCLES + 5) @(posedge clk);
  endtask

  task automatic set_window(int unsigned len);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= cfg_t'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
    win_len = len;
    clear_window();
  endtask

  task automatic queue_random(int n, int unsigned lo, int unsigned hi);
    for (int i = 0; i < n; i++) begin
      pending_samples.push_back(sample_t'($urandom_range(hi, lo)));
    end
  endtask

  task automatic queue_windowed(int n);
    int unsigned base;
    for (int i = 0; i < n; i++) begin
      base = $urandom_range(120);
      if ($urandom_range(9) < 2) begin
        pending_samples.push_back(sample_t'($urandom_range(255)));
      end else if ($urandom_range(9) < 2) begin
        pending_samples.push_back(sample_t'(2 * base + $urandom_range(1)));
      end else begin
        pending_samples.push_back(sample_t'($urandom_range(base + 10, base)));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    win_len = CFG_RESET;
    alert_tally = '0;
    foreach (ring[i]) ring[i] = '0;
    clear_window();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words with the reset window: extremes, ties and alerts.
    pending_samples = '{8'd0, 8'd255, 8'd10, 8'd10, 8'd20, 8'd20, 8'd19, 8'd0, 8'd255,
                        8'd128, 8'd127, 8'd40, 8'd40, 8'd85, 8'd170, 8'd0, 8'd0, 8'd0,
                        8'd0, 8'd1, 8'd0};
    drain();

    set_window(0);
    queue_random(12, 0, 255);
    drain();
    set_window(2);
    pending_samples = '{8'd3, 8'd7, 8'd20, 8'd9, 8'd255, 8'd0};
    queue_windowed(60);
    drain();

    send_idle_pct = 53;
    set_window(1);
    queue_windowed(100);
    drain();
    recv_stall_pct = 53;
    send_idle_pct = 0;
    set_window(7);
    queue_windowed(150);
    drain();
    send_idle_pct = 29;
    recv_stall_pct = 29;
    set_window(4);
    queue_windowed(150);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_window(2047);
    queue_random(40, 0, 255);
    drain();
    set_window(300);
    queue_random(310, 0, 255);
    queue_windowed(40);
    drain();
    set_window(16);
    queue_windowed(100);
    drain();

    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

### filelist.f
hw/rtl/smtd_pkg.sv
hw/rtl/smtd_if.sv
hw/rtl/smtd_cell.sv
hw/rtl/sliding_median_threshold_detector_top.sv
bench/sliding_median_threshold_detector_top_test.sv
